// ===== src/assert_macros.svh =====
// assertion macros used by the converter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/rgb2yuv_pkg.sv =====
// ============================================================================
// rgb2yuv_pkg
// Shared types, constants and arithmetic helpers for the rgb to yuv 4:2:0
// converter.
// ============================================================================
package rgb2yuv_pkg;

    // frame geometry
    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = $clog2(MAX_DIMENSION + 1);
    localparam int CNT_W         = $clog2(MAX_DIMENSION);

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(480);

    // color math
    localparam int PIX_W = 8;
    localparam int SUM_W = 18;

    localparam logic signed [SUM_W-1:0] Y_COEF_R  = 18'sd66;
    localparam logic signed [SUM_W-1:0] Y_COEF_G  = 18'sd129;
    localparam logic signed [SUM_W-1:0] Y_COEF_B  = 18'sd25;
    localparam logic signed [SUM_W-1:0] U_COEF_R  = -18'sd38;
    localparam logic signed [SUM_W-1:0] U_COEF_G  = -18'sd74;
    localparam logic signed [SUM_W-1:0] U_COEF_B  = 18'sd112;
    localparam logic signed [SUM_W-1:0] V_COEF_R  = 18'sd112;
    localparam logic signed [SUM_W-1:0] V_COEF_G  = -18'sd94;
    localparam logic signed [SUM_W-1:0] V_COEF_B  = -18'sd18;
    localparam logic signed [SUM_W-1:0] ROUND     = 18'sd128;
    localparam logic signed [SUM_W-1:0] Y_OFFSET  = 18'sd16;
    localparam logic signed [SUM_W-1:0] C_OFFSET  = 18'sd128;
    localparam logic signed [SUM_W-1:0] PIX_MAX   = 18'sd255;

    // position of one item inside the frame
    typedef struct packed {
        logic even_col;
        logic odd_row;
        logic frame_end;
    } pos_info_t;

    // floor shift, offset and clip to one byte
    function automatic logic [PIX_W-1:0] clip_sample(
        input logic signed [SUM_W-1:0] sum,
        input logic signed [SUM_W-1:0] offset
    );
        logic signed [SUM_W-1:0] val;
        val = (sum >>> 8) + offset;
        if (val < 0)
        begin
            return '0;
        end
        else if (val > PIX_MAX)
        begin
            return '1;
        end
        else
        begin
            return val[PIX_W-1:0];
        end
    endfunction

endpackage

// ===== src/rgb2yuv_regs.sv =====
// ============================================================================
// rgb2yuv_regs
// APB-style configuration registers: frame width and frame height.
// ============================================================================
module rgb2yuv_regs
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rgb2yuv_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rgb2yuv_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rgb2yuv_pkg::APB_DATA_W-1:0]     prdata,
    output logic [rgb2yuv_pkg::DIM_W-1:0]          frame_width,
    output logic [rgb2yuv_pkg::DIM_W-1:0]          frame_height
);

    logic [rgb2yuv_pkg::DIM_W-1:0]     frame_width_reg;
    logic [rgb2yuv_pkg::DIM_W-1:0]     frame_height_reg;
    logic [rgb2yuv_pkg::DIM_W-1:0]     frame_width_next;
    logic [rgb2yuv_pkg::DIM_W-1:0]     frame_height_next;
    logic [rgb2yuv_pkg::REG_IDX_W-1:0] reg_idx;
    logic                              wr_en;

    // register index from the word address
    assign reg_idx = paddr[rgb2yuv_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // write decode
    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (wr_en)
        begin
            case (reg_idx)
                rgb2yuv_pkg::REG_FRAME_WIDTH:
                begin
                    frame_width_next = pwdata[rgb2yuv_pkg::DIM_W-1:0];
                end
                rgb2yuv_pkg::REG_FRAME_HEIGHT:
                begin
                    frame_height_next = pwdata[rgb2yuv_pkg::DIM_W-1:0];
                end
                default:
                begin
                    frame_width_next = frame_width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= rgb2yuv_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= rgb2yuv_pkg::FRAME_HEIGHT_RESET;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            rgb2yuv_pkg::REG_FRAME_WIDTH:
            begin
                prdata = rgb2yuv_pkg::APB_DATA_W'(frame_width_reg);
            end
            rgb2yuv_pkg::REG_FRAME_HEIGHT:
            begin
                prdata = rgb2yuv_pkg::APB_DATA_W'(frame_height_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign frame_width  = frame_width_reg;
    assign frame_height = frame_height_reg;

endmodule

// ===== src/rgb2yuv_position.sv =====
// ============================================================================
// rgb2yuv_position
// Column and row counters that track the raster position of each item
// against the configured frame size.
// ============================================================================
module rgb2yuv_position
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [rgb2yuv_pkg::DIM_W-1:0]      frame_width,
    input  logic [rgb2yuv_pkg::DIM_W-1:0]      frame_height,
    input  logic                               advance,
    output rgb2yuv_pkg::pos_info_t             pos
);

    logic [rgb2yuv_pkg::CNT_W-1:0] col_reg;
    logic [rgb2yuv_pkg::CNT_W-1:0] row_reg;
    logic [rgb2yuv_pkg::CNT_W-1:0] col_next;
    logic [rgb2yuv_pkg::CNT_W-1:0] row_next;
    logic [rgb2yuv_pkg::DIM_W-1:0] eff_width;
    logic [rgb2yuv_pkg::DIM_W-1:0] eff_height;
    logic                          last_col;
    logic                          last_row;

    // zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (frame_width == '0)
        begin
            eff_width = rgb2yuv_pkg::DIM_W'(1);
        end
        else if (frame_width > rgb2yuv_pkg::DIM_W'(rgb2yuv_pkg::MAX_DIMENSION))
        begin
            eff_width = rgb2yuv_pkg::DIM_W'(rgb2yuv_pkg::MAX_DIMENSION);
        end
        else
        begin
            eff_width = frame_width;
        end

        if (frame_height == '0)
        begin
            eff_height = rgb2yuv_pkg::DIM_W'(1);
        end
        else if (frame_height > rgb2yuv_pkg::DIM_W'(rgb2yuv_pkg::MAX_DIMENSION))
        begin
            eff_height = rgb2yuv_pkg::DIM_W'(rgb2yuv_pkg::MAX_DIMENSION);
        end
        else
        begin
            eff_height = frame_height;
        end
    end

    // a counter at or past the last position counts as the last position
    assign last_col = (rgb2yuv_pkg::DIM_W'(col_reg) + rgb2yuv_pkg::DIM_W'(1)) >= eff_width;
    assign last_row = (rgb2yuv_pkg::DIM_W'(row_reg) + rgb2yuv_pkg::DIM_W'(1)) >= eff_height;

    // counter advance on each accepted item
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign pos.even_col  = ~col_reg[0];
    assign pos.odd_row   = row_reg[0];
    assign pos.frame_end = last_col && last_row;

endmodule

// ===== src/rgb2yuv_csc.sv =====
// ============================================================================
// rgb2yuv_csc
// BT.601 integer color conversion: luma for every item, U or V for items in
// even columns.
// ============================================================================
module rgb2yuv_csc
(
    input  logic [rgb2yuv_pkg::PIX_W-1:0]  red,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]  green,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]  blue,
    input  rgb2yuv_pkg::pos_info_t         pos,
    output logic [rgb2yuv_pkg::PIX_W-1:0]  luma,
    output logic [rgb2yuv_pkg::PIX_W-1:0]  chroma,
    output logic                           chroma_valid,
    output logic                           chroma_is_v
);

    logic signed [rgb2yuv_pkg::SUM_W-1:0] r_s;
    logic signed [rgb2yuv_pkg::SUM_W-1:0] g_s;
    logic signed [rgb2yuv_pkg::SUM_W-1:0] b_s;
    logic signed [rgb2yuv_pkg::SUM_W-1:0] y_sum;
    logic signed [rgb2yuv_pkg::SUM_W-1:0] c_sum;

    // widen to signed
    assign r_s = $signed({{(rgb2yuv_pkg::SUM_W - rgb2yuv_pkg::PIX_W){1'b0}}, red});
    assign g_s = $signed({{(rgb2yuv_pkg::SUM_W - rgb2yuv_pkg::PIX_W){1'b0}}, green});
    assign b_s = $signed({{(rgb2yuv_pkg::SUM_W - rgb2yuv_pkg::PIX_W){1'b0}}, blue});

    // luma
    assign y_sum = rgb2yuv_pkg::Y_COEF_R * r_s + rgb2yuv_pkg::Y_COEF_G * g_s
                 + rgb2yuv_pkg::Y_COEF_B * b_s + rgb2yuv_pkg::ROUND;
    assign luma  = rgb2yuv_pkg::clip_sample(y_sum, rgb2yuv_pkg::Y_OFFSET);

    // chroma: V on odd rows, U on even rows
    always_comb
    begin
        if (pos.odd_row)
        begin
            c_sum = rgb2yuv_pkg::V_COEF_R * r_s + rgb2yuv_pkg::V_COEF_G * g_s
                  + rgb2yuv_pkg::V_COEF_B * b_s + rgb2yuv_pkg::ROUND;
        end
        else
        begin
            c_sum = rgb2yuv_pkg::U_COEF_R * r_s + rgb2yuv_pkg::U_COEF_G * g_s
                  + rgb2yuv_pkg::U_COEF_B * b_s + rgb2yuv_pkg::ROUND;
        end
    end

    // odd columns carry no chroma
    assign chroma_valid = pos.even_col;
    assign chroma_is_v  = pos.even_col && pos.odd_row;
    assign chroma       = pos.even_col
                        ? rgb2yuv_pkg::clip_sample(c_sum, rgb2yuv_pkg::C_OFFSET) : '0;

endmodule

// ===== src/rgb_to_yuv420_converter_top.sv =====
// ============================================================================
// rgb_to_yuv420_converter_top
// RGB24 to YUV 4:2:0 pixel converter, BT.601 integer form.
// ============================================================================
// One pixel item is taken per clock while in_ready is high, and one result
// item comes out per pixel. An accepted item is captured, with its raster
// position, in the input register; the color conversion runs between that
// register and the output register, which loads the result once it is free
// or being drained. in_ready is high while the input register is empty or
// the output register is free or being drained, so sustained throughput is
// one item per cycle; a stalled output only holds the input once both
// registers are full. Frame width and height are set through the APB port
// (byte addresses 0 and 4); a new size applies from the next accepted item,
// and a position at or past a shrunk size counts as the last.
module rgb_to_yuv420_converter_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rgb2yuv_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rgb2yuv_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rgb2yuv_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                pready,
    // pixel input
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]       red,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]       green,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]       blue,
    // result output
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rgb2yuv_pkg::PIX_W-1:0]       luma,
    output logic [rgb2yuv_pkg::PIX_W-1:0]       chroma,
    output logic                                chroma_valid,
    output logic                                chroma_is_v,
    output logic                                frame_end
);

    logic [rgb2yuv_pkg::DIM_W-1:0]  frame_width;
    logic [rgb2yuv_pkg::DIM_W-1:0]  frame_height;
    rgb2yuv_pkg::pos_info_t         cur_pos;
    logic                           in_accept;
    logic                           out_free;

    // input stage
    logic                           in_valid_reg;
    logic                           in_valid_next;
    logic [rgb2yuv_pkg::PIX_W-1:0]  red_reg;
    logic [rgb2yuv_pkg::PIX_W-1:0]  green_reg;
    logic [rgb2yuv_pkg::PIX_W-1:0]  blue_reg;
    rgb2yuv_pkg::pos_info_t         pos_reg;

    // conversion results
    logic [rgb2yuv_pkg::PIX_W-1:0]  luma_next;
    logic [rgb2yuv_pkg::PIX_W-1:0]  chroma_next;
    logic                           chroma_valid_next;
    logic                           chroma_is_v_next;

    // output stage
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [rgb2yuv_pkg::PIX_W-1:0]  luma_reg;
    logic [rgb2yuv_pkg::PIX_W-1:0]  chroma_reg;
    logic                           chroma_valid_reg;
    logic                           chroma_is_v_reg;
    logic                           frame_end_reg;

    // configuration registers
    rgb2yuv_regs u_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .frame_width  (frame_width),
        .frame_height (frame_height)
    );

    assign pready = 1'b1;

    // handshake
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || out_free;
    assign in_accept = in_valid && in_ready;

    // raster position of the incoming item
    rgb2yuv_position u_position
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .advance      (in_accept),
        .pos          (cur_pos)
    );

    // input register
    always_comb
    begin
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            pos_reg   <= cur_pos;
        end
    end

    // color conversion
    rgb2yuv_csc u_csc
    (
        .red          (red_reg),
        .green        (green_reg),
        .blue         (blue_reg),
        .pos          (pos_reg),
        .luma         (luma_next),
        .chroma       (chroma_next),
        .chroma_valid (chroma_valid_next),
        .chroma_is_v  (chroma_is_v_next)
    );

    // output register
    assign out_valid_next = out_free ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && in_valid_reg)
        begin
            luma_reg         <= luma_next;
            chroma_reg       <= chroma_next;
            chroma_valid_reg <= chroma_valid_next;
            chroma_is_v_reg  <= chroma_is_v_next;
            frame_end_reg    <= pos_reg.frame_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign luma         = luma_reg;
    assign chroma       = chroma_reg;
    assign chroma_valid = chroma_valid_reg;
    assign chroma_is_v  = chroma_is_v_reg;
    assign frame_end    = frame_end_reg;

    // checks
`include "assert_macros.svh"

    `ASSERT_CLK(a_stall_means_full, !in_ready |-> (in_valid_reg && out_valid_reg), "in_ready low with a free stage")
    `ASSERT_CLK(a_frame_wraps, (in_accept && cur_pos.frame_end) |=> (cur_pos.even_col && !cur_pos.odd_row), "position did not wrap after frame end")
    `ASSERT_NEVER(a_v_without_chroma, out_valid_reg && chroma_is_v_reg && !chroma_valid_reg, "V flagged on an item without chroma")
    `ASSERT_NEVER(a_stray_chroma, out_valid_reg && !chroma_valid_reg && (chroma_reg != '0), "chroma value on an item without chroma")

endmodule
